@@ sv/clook_pkg.sv @@
// Shared types and constants for the C-LOOK disk scheduler.
// Used by the loader, sweep engine and top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package clook_pkg;

  localparam int unsigned CYL_W            = 8;
  localparam int unsigned COST_W           = 10;
  localparam int unsigned DIST_W           = 9;
  localparam int unsigned MAP_DEPTH_MAX    = 256;
  localparam int unsigned CYLINDERS_DEF    = 256;
  localparam int unsigned MAX_REQUESTS_DEF = 64;

  localparam logic [COST_W-1:0] COST_MAX   = 10'd1023;
  localparam logic [DIST_W-1:0] NO_NEAREST = 9'd511;

  typedef struct packed {
    logic [CYL_W-1:0] request_cylinder;
    logic             last_request;
  } in_req_t;

  typedef struct packed {
    logic [CYL_W-1:0]  serviced_cylinder;
    logic [COST_W-1:0] running_cost;
    logic              final_item;
  } out_rsp_t;

  typedef struct packed {
    logic [CYL_W-1:0] start;
    logic             down;
  } batch_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_START,
    ST_SWEEP
  } state_e;

endpackage

`default_nettype wire

@@ sv/clook_map_ram.sv @@
// Presence bitmap memory: one write port, one read port with registered data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module clook_map_ram #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic          wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic               rdata_o
);

  logic mem [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/clook_loader.sv @@
// Batch tracker: start head, nearest other request and request count.
// Depends on clook_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clook_loader #(
  parameter int unsigned MAP_LEN      = 256,
  parameter int unsigned MAX_REQUESTS = 64,
  localparam int unsigned CNT_W       = $clog2(MAX_REQUESTS + 1),
  localparam int unsigned LIM_W       = clook_pkg::CYL_W + 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [clook_pkg::CYL_W-1:0]   cyl_i,
  input  wire logic                          clear_i,
  output logic                               load_o,
  output logic                               loaded_o,
  output clook_pkg::batch_t                  batch_o
);

  logic [CNT_W-1:0]                count_q, count_d;
  logic [clook_pkg::CYL_W-1:0]     start_q, start_d;
  logic [clook_pkg::DIST_W-1:0]    near_dist_q, near_dist_d;
  logic [clook_pkg::CYL_W-1:0]     near_pos_q, near_pos_d;
  logic                            in_range;
  logic                            full;
  logic [clook_pkg::CYL_W-1:0]     diff;

  assign in_range = {1'b0, cyl_i} < LIM_W'(MAP_LEN);
  assign full     = count_q == CNT_W'(MAX_REQUESTS);
  assign load_o   = accept_i && in_range && !full;
  assign diff     = (cyl_i > start_q) ? (cyl_i - start_q) : (start_q - cyl_i);

  always_comb begin
    count_d     = count_q;
    start_d     = start_q;
    near_dist_d = near_dist_q;
    near_pos_d  = near_pos_q;
    if (clear_i) begin
      count_d     = '0;
      start_d     = '0;
      near_dist_d = clook_pkg::NO_NEAREST;
      near_pos_d  = '0;
    end else if (load_o) begin
      count_d = count_q + CNT_W'(1);
      if (count_q == '0) begin
        start_d = cyl_i;
      end else if (clook_pkg::DIST_W'(diff) < near_dist_q) begin
        near_dist_d = clook_pkg::DIST_W'(diff);
        near_pos_d  = cyl_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      start_q     <= '0;
      near_dist_q <= clook_pkg::NO_NEAREST;
      near_pos_q  <= '0;
    end else begin
      count_q     <= count_d;
      start_q     <= start_d;
      near_dist_q <= near_dist_d;
      near_pos_q  <= near_pos_d;
    end
  end

  assign loaded_o      = count_q != '0;
  assign batch_o.start = start_q;
  assign batch_o.down  = (near_dist_q != clook_pkg::NO_NEAREST) && (near_pos_q < start_q);

endmodule

`default_nettype wire

@@ sv/clook_sweep.sv @@
// Sweep engine: walks the bitmap around from the start head, clears each
// cylinder it reads and builds the result stream. Depends on clook_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clook_sweep #(
  parameter int unsigned MAP_LEN = 256,
  localparam int unsigned MAP_AW = $clog2(MAP_LEN)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire clook_pkg::batch_t   batch_i,
  output logic                     map_re_o,
  output logic [MAP_AW-1:0]        map_raddr_o,
  input  wire logic                map_rdata_i,
  output logic                     map_we_o,
  output logic [MAP_AW-1:0]        map_waddr_o,
  output logic                     done_o,
  output logic                     out_valid_o,
  output clook_pkg::out_rsp_t      out_rsp_o,
  input  wire logic                out_stall_i
);

  localparam logic [MAP_AW-1:0] LAST_ADDR = MAP_AW'(MAP_LEN - 1);
  localparam int unsigned SUM_W = clook_pkg::COST_W + 1;

  logic                           adv, issue, hit, iss_last;
  logic                           down_q;
  logic                           iss_busy_q;
  logic [MAP_AW-1:0]              iss_addr_q, iss_addr_nxt;
  logic [MAP_AW-1:0]              iss_cnt_q;
  logic                           s1_valid_q, s1_last_q;
  logic [MAP_AW-1:0]              s1_addr_q;
  logic                           pend_valid_q, flush_q;
  logic [clook_pkg::CYL_W-1:0]    pend_cyl_q, head_q, hit_cyl;
  logic [clook_pkg::COST_W-1:0]   pend_cost_q, cost_q, new_cost;
  logic [clook_pkg::CYL_W-1:0]    diff;
  logic [SUM_W-1:0]               sum;
  logic                           out_valid_q;
  clook_pkg::out_rsp_t            out_rsp_q;

  assign adv      = !out_valid_q || !out_stall_i;
  assign issue    = iss_busy_q && adv;
  assign hit      = s1_valid_q && map_rdata_i;
  assign iss_last = iss_cnt_q == LAST_ADDR;

  always_comb begin
    if (down_q) begin
      iss_addr_nxt = (iss_addr_q == '0) ? LAST_ADDR : iss_addr_q - MAP_AW'(1);
    end else begin
      iss_addr_nxt = (iss_addr_q == LAST_ADDR) ? '0 : iss_addr_q + MAP_AW'(1);
    end
  end

  assign hit_cyl  = clook_pkg::CYL_W'(s1_addr_q);
  assign diff     = (head_q > hit_cyl) ? (head_q - hit_cyl) : (hit_cyl - head_q);
  assign sum      = SUM_W'(cost_q) + SUM_W'(diff);
  assign new_cost = (sum > SUM_W'(clook_pkg::COST_MAX)) ? clook_pkg::COST_MAX
                                                        : sum[clook_pkg::COST_W-1:0];

  assign map_re_o    = issue;
  assign map_raddr_o = iss_addr_q;
  assign map_we_o    = adv && s1_valid_q;
  assign map_waddr_o = s1_addr_q;
  assign done_o      = adv && flush_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_busy_q   <= 1'b0;
      s1_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      flush_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (start_i) begin
      iss_busy_q   <= 1'b1;
      s1_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      flush_q      <= 1'b0;
      if (adv) begin
        out_valid_q <= 1'b0;
      end
    end else if (adv) begin
      s1_valid_q  <= issue;
      if (issue && iss_last) begin
        iss_busy_q <= 1'b0;
      end
      out_valid_q <= (hit && pend_valid_q) || flush_q;
      if (hit) begin
        pend_valid_q <= 1'b1;
      end
      flush_q <= s1_valid_q && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      down_q     <= batch_i.down;
      iss_addr_q <= MAP_AW'(batch_i.start);
      iss_cnt_q  <= '0;
      head_q     <= batch_i.start;
      cost_q     <= '0;
    end else if (adv) begin
      s1_addr_q <= iss_addr_q;
      s1_last_q <= iss_last;
      if (issue) begin
        iss_addr_q <= iss_addr_nxt;
        iss_cnt_q  <= iss_cnt_q + MAP_AW'(1);
      end
      if (hit && pend_valid_q) begin
        out_rsp_q.serviced_cylinder <= pend_cyl_q;
        out_rsp_q.running_cost      <= pend_cost_q;
        out_rsp_q.final_item        <= 1'b0;
      end else if (flush_q) begin
        out_rsp_q.serviced_cylinder <= pend_cyl_q;
        out_rsp_q.running_cost      <= pend_cost_q;
        out_rsp_q.final_item        <= 1'b1;
      end
      if (hit) begin
        pend_cyl_q  <= hit_cyl;
        pend_cost_q <= new_cost;
        head_q      <= hit_cyl;
        cost_q      <= new_cost;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

@@ sv/clook_disk_scheduler.sv @@
// Top level of the C-LOOK disk scheduler: control sequencer, bitmap memory,
// batch tracker and sweep engine. Depends on clook_pkg and the clook_* modules.
//
// Usage: requests arrive on in_valid_i / in_stall_o / in_req_i, one per
// cycle while the block is loading. The first request of a batch sets the
// start head; every in-range request, up to MAX_REQUESTS per batch, marks
// its cylinder in a bitmap memory. A request with last_request set closes
// the batch and, if it loaded any request, starts the sweep. Results leave
// on out_valid_o / out_stall_i / out_rsp_o, one per serviced cylinder, the
// last one flagged with final_item. The sweep reads one bitmap entry per
// cycle while the output is not stalled, over all MAP_LEN entries (MAP_LEN
// = min(CYLINDERS, 256)); in_stall_o is high until the sweep is done.
// The output register holds a result until taken; a stalled output pauses
// the sweep without loss. The next batch may load while the final result
// still waits.
// After reset the block runs a clearing pass over all MAP_LEN bitmap
// entries, with in_stall_o high, before it takes its first request.
`timescale 1ns / 1ps
`default_nettype none

module clook_disk_scheduler #(
  parameter int unsigned CYLINDERS    = clook_pkg::CYLINDERS_DEF,
  parameter int unsigned MAX_REQUESTS = clook_pkg::MAX_REQUESTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire clook_pkg::in_req_t  in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output clook_pkg::out_rsp_t      out_rsp_o
);

  localparam int unsigned MAP_LEN = (CYLINDERS < clook_pkg::MAP_DEPTH_MAX)
                                    ? CYLINDERS : clook_pkg::MAP_DEPTH_MAX;
  localparam int unsigned MAP_AW  = $clog2(MAP_LEN);
  localparam logic [MAP_AW-1:0] LAST_ADDR = MAP_AW'(MAP_LEN - 1);

  clook_pkg::state_e   state_q, state_d;
  logic [MAP_AW-1:0]   clr_q;
  logic                accept, load, loaded, go, sweep_start, batch_clear;
  clook_pkg::batch_t   batch;
  logic                sw_re, sw_we, sw_done;
  logic [MAP_AW-1:0]   sw_raddr, sw_waddr;
  logic                mem_we, mem_wdata, mem_rdata;
  logic [MAP_AW-1:0]   mem_waddr;

  assign accept = in_valid_i && !in_stall_o;
  assign go     = accept && in_req_i.last_request && (loaded || load);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      clook_pkg::ST_CLEAR: begin
        if (clr_q == LAST_ADDR) begin
          state_d = clook_pkg::ST_LOAD;
        end
      end
      clook_pkg::ST_LOAD: begin
        if (go) begin
          state_d = clook_pkg::ST_START;
        end
      end
      clook_pkg::ST_START: begin
        state_d = clook_pkg::ST_SWEEP;
      end
      clook_pkg::ST_SWEEP: begin
        if (sw_done) begin
          state_d = clook_pkg::ST_LOAD;
        end
      end
      default: state_d = clook_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    sweep_start = 1'b0;
    batch_clear = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = sw_waddr;
    mem_wdata   = 1'b0;
    unique case (state_q)
      clook_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      clook_pkg::ST_LOAD: begin
        in_stall_o = 1'b0;
        mem_we     = load;
        mem_waddr  = MAP_AW'(in_req_i.request_cylinder);
        mem_wdata  = 1'b1;
        batch_clear = accept && in_req_i.last_request && !go;
      end
      clook_pkg::ST_START: begin
        sweep_start = 1'b1;
        batch_clear = 1'b1;
      end
      clook_pkg::ST_SWEEP: begin
        mem_we = sw_we;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clook_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == clook_pkg::ST_CLEAR) begin
        clr_q <= clr_q + MAP_AW'(1);
      end
    end
  end

  clook_map_ram #(
    .DEPTH (MAP_LEN)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (sw_re),
    .raddr_i (sw_raddr),
    .rdata_o (mem_rdata)
  );

  clook_loader #(
    .MAP_LEN      (MAP_LEN),
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_loader (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cyl_i    (in_req_i.request_cylinder),
    .clear_i  (batch_clear),
    .load_o   (load),
    .loaded_o (loaded),
    .batch_o  (batch)
  );

  clook_sweep #(
    .MAP_LEN (MAP_LEN)
  ) u_sweep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (sweep_start),
    .batch_i     (batch),
    .map_re_o    (sw_re),
    .map_raddr_o (sw_raddr),
    .map_rdata_i (mem_rdata),
    .map_we_o    (sw_we),
    .map_waddr_o (sw_waddr),
    .done_o      (sw_done),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire
